### src/ssae_pkg.sv
// ----------------------------------------------------------------------------
// ssae_pkg: shared types and constants for the sorted set algebra engine
// Request and operation codes, element type and the front/back command word.
// ----------------------------------------------------------------------------
package ssae_pkg;

	localparam int SetCapacity  = 8;
	localparam int ElementWidth = 32;
	localparam int IdxW = $clog2(SetCapacity);
	localparam int CntW = $clog2(SetCapacity + 1);
	localparam int QueueDepth = 2;

	typedef logic signed [31:0] elem_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;

	typedef enum logic [1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_COMPUTE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OP_UNION = 3'd0,
		OP_INTER = 3'd1,
		OP_AMB   = 3'd2,
		OP_BMA   = 3'd3,
		OP_SYMD  = 3'd4,
		OP_PROD  = 3'd5,
		OP_BAD6  = 3'd6,
		OP_BAD7  = 3'd7
	} op_t;

	localparam logic [1:0] StOk   = 2'd0;
	localparam logic [1:0] StDup  = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	// command passed from front to back
	typedef struct packed {
		req_t  req;
		op_t   op;
		elem_t value;
	} cmd_t;

	// result item
	typedef struct packed {
		elem_t      value;
		elem_t      second;
		logic       last;
		logic       empty;
		logic [1:0] status;
	} res_t;

	// low ElementWidth bits, sign extended
	function automatic elem_t sext_elem(input elem_t raw);
		elem_t r;
		if (ElementWidth >= 32) begin
			r = raw;
		end else begin
			r = raw <<< (32 - ElementWidth);
			r = r >>> (32 - ElementWidth);
		end
		return r;
	endfunction

endpackage

### src/ssae_front.sv
// ----------------------------------------------------------------------------
// ssae_front: request intake
// Accepts requests, normalizes the element and queues commands for the back.
// ----------------------------------------------------------------------------
module ssae_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    req_type,
	input  logic signed [31:0] element_value,
	input  logic [2:0]    operation,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output ssae_pkg::cmd_t cmd
);
	import ssae_pkg::*;

	cmd_t q_mem_q [QueueDepth];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t in_cmd;

	// classify and normalize the incoming request
	always_comb begin
		in_cmd.req   = req_t'(req_type);
		in_cmd.op    = op_t'(operation);
		in_cmd.value = sext_elem(element_value);
	end

	assign full      = (cnt_q == 2'(QueueDepth));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_q];

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				q_mem_q[wr_q] <= in_cmd;
				wr_q <= ~wr_q;
			end
			if (cmd_take && cmd_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end

endmodule

### src/ssae_back.sv
// ----------------------------------------------------------------------------
// ssae_back: set storage and execution
// Sorted insert by a search walk plus shift, merge walk and product walk,
// one stored element per cycle while the output queue has room, results into a two-entry output queue.
// ----------------------------------------------------------------------------
module ssae_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  ssae_pkg::cmd_t cmd,
	output logic          res_empty,
	input  logic          pop,
	output ssae_pkg::res_t res
);
	import ssae_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_SHIFT, S_MERGE, S_PROD, S_FLUSH
	} state_t;

	state_t state_q;
	elem_t  a_q [SetCapacity];
	elem_t  b_q [SetCapacity];
	cnt_t   na_q, nb_q;
	cmd_t   cur_q;
	cnt_t   i_q, j_q;
	res_t   pend_q;
	logic   pend_v_q;

	// output queue
	res_t   oq_q [2];
	logic   ow_q, or_q;
	logic [1:0] ocnt_q;
	logic   o_push;
	res_t   o_item;
	logic   o_room;

	assign res_empty = (ocnt_q == 2'd0);
	assign res       = oq_q[or_q];
	assign o_room    = (ocnt_q != 2'd2);

	// working set for load
	logic   is_b;
	cnt_t   n_sel;
	elem_t  ea, eb, es;
	logic   ia, jb;
	logic   keep_a, keep_both, keep_b;

	// walk step decode
	logic   m_done, m_a_only, m_b_only, m_take;
	elem_t  m_val;
	logic   p_done;
	logic   step_take, stall;

	always_comb begin
		is_b  = (cur_q.req == REQ_LOAD_B);
		n_sel = is_b ? nb_q : na_q;
		ea = a_q[i_q[IdxW-1:0]];
		eb = b_q[j_q[IdxW-1:0]];
		es = is_b ? b_q[i_q[IdxW-1:0]] : a_q[i_q[IdxW-1:0]];
		ia = (i_q < na_q);
		jb = (j_q < nb_q);
		keep_a = 1'b0; keep_both = 1'b0; keep_b = 1'b0;
		case (cur_q.op)
			OP_UNION: begin keep_a = 1'b1; keep_both = 1'b1; keep_b = 1'b1; end
			OP_INTER: keep_both = 1'b1;
			OP_AMB:   keep_a = 1'b1;
			OP_BMA:   keep_b = 1'b1;
			OP_SYMD:  begin keep_a = 1'b1; keep_b = 1'b1; end
			default:  ;
		endcase
	end

	// merge step: which side is smaller and whether it is kept
	always_comb begin
		m_done   = !ia && !jb;
		m_a_only = !jb || (ia && ea < eb);
		m_b_only = !m_a_only && (!ia || eb < ea);
		m_take   = m_a_only ? keep_a : (m_b_only ? keep_b : keep_both);
		m_val    = m_b_only ? eb : ea;
		p_done   = !ia || (nb_q == '0);
		step_take = ((state_q == S_MERGE) && !m_done && m_take) ||
			((state_q == S_PROD) && !p_done);
		stall     = step_take && pend_v_q && !o_room;
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	// held item goes out when the next one replaces it, so last is known
	always_comb begin
		o_push = 1'b0;
		o_item = pend_q;
		if (state_q == S_FLUSH && o_room)
			o_push = 1'b1;
		else if (step_take && pend_v_q && o_room)
			o_push = 1'b1;
	end

	// sequencer: one step per cycle, stalls when the output queue has no room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			na_q     <= '0;
			nb_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q    <= cmd;
						i_q      <= '0;
						j_q      <= '0;
						pend_v_q <= 1'b0;
						case (cmd.req)
							REQ_LOAD_A, REQ_LOAD_B: state_q <= S_SEARCH;
							REQ_CLEAR: begin
								na_q <= '0;
								nb_q <= '0;
								pend_q   <= '{value: '0, second: '0, last: 1'b1,
									empty: 1'b0, status: StOk};
								state_q  <= S_FLUSH;
							end
							default: begin
								if (cmd.op == OP_PROD)
									state_q <= S_PROD;
								else if (cmd.op == OP_BAD6 || cmd.op == OP_BAD7) begin
									pend_q  <= '{value: '0, second: '0, last: 1'b1,
										empty: 1'b1, status: StOk};
									state_q <= S_FLUSH;
								end else
									state_q <= S_MERGE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (i_q < n_sel && es < cur_q.value) begin
						i_q <= i_q + 1'b1;
					end else if (i_q < n_sel && es == cur_q.value) begin
						pend_q <= '{value: '0, second: '0, last: 1'b1,
							empty: 1'b0, status: StDup};
						state_q <= S_FLUSH;
					end else if (n_sel >= cnt_t'(SetCapacity)) begin
						pend_q <= '{value: '0, second: '0, last: 1'b1,
							empty: 1'b0, status: StFull};
						state_q <= S_FLUSH;
					end else begin
						pend_q <= '{value: '0, second: '0, last: 1'b1,
							empty: 1'b0, status: StOk};
						j_q <= n_sel;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// move entries up one at a time from the top down to pos
					if (j_q == i_q) begin
						if (is_b) begin
							b_q[j_q[IdxW-1:0]] <= cur_q.value;
							nb_q <= nb_q + 1'b1;
						end else begin
							a_q[j_q[IdxW-1:0]] <= cur_q.value;
							na_q <= na_q + 1'b1;
						end
						state_q <= S_FLUSH;
					end else begin
						if (is_b)
							b_q[j_q[IdxW-1:0]] <= b_q[IdxW'(j_q - 1'b1)];
						else
							a_q[j_q[IdxW-1:0]] <= a_q[IdxW'(j_q - 1'b1)];
						j_q <= j_q - 1'b1;
					end
				end
				S_MERGE: begin
					if (!stall) begin
						if (m_done) begin
							// mark the held item last, or report an empty set
							if (pend_v_q)
								pend_q.last <= 1'b1;
							else
								pend_q <= '{value: '0, second: '0, last: 1'b1,
									empty: 1'b1, status: StOk};
							state_q <= S_FLUSH;
						end else begin
							if (!m_b_only)
								i_q <= i_q + 1'b1;
							if (!m_a_only)
								j_q <= j_q + 1'b1;
							if (m_take) begin
								pend_q <= '{value: m_val, second: '0, last: 1'b0,
									empty: 1'b0, status: StOk};
								pend_v_q <= 1'b1;
							end
						end
					end
				end
				S_PROD: begin
					if (!stall) begin
						if (p_done) begin
							if (pend_v_q)
								pend_q.last <= 1'b1;
							else
								pend_q <= '{value: '0, second: '0, last: 1'b1,
									empty: 1'b1, status: StOk};
							state_q <= S_FLUSH;
						end else begin
							pend_q <= '{value: ea, second: eb, last: 1'b0,
								empty: 1'b0, status: StOk};
							pend_v_q <= 1'b1;
							if (j_q == nb_q - 1'b1) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else
								j_q <= j_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (o_room) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output queue storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= 1'b0;
			or_q   <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (o_push) begin
				oq_q[ow_q] <= o_item;
				ow_q <= ~ow_q;
			end
			if (pop && !res_empty)
				or_q <= ~or_q;
			ocnt_q <= ocnt_q + 2'(o_push) - 2'(pop && !res_empty);
		end
	end

endmodule

### src/sorted_set_algebra_engine.sv
// ----------------------------------------------------------------------------
// sorted_set_algebra_engine: two sorted sets with union/intersect/diff/product
// Front queues requests, back holds the sets and walks them.
// ----------------------------------------------------------------------------
// channel | direction | handshake    | payload
// request | in        | push / full  | req_type, element_value, operation
// result  | out       | pop / empty  | result_value, pair_second, last_flag,
//         |           |              | empty_flag, status
//
// A request is registered in the request queue, then the back takes it when idle.
// A load walks one search step per smaller stored element, one shift step per
// larger one, then writes the element and flushes a status item.
// A compute walks one step per cycle while the result queue has room (at most
// na + nb merge steps, or na * nb pairs), then a closing step and a flush.
// Reset clears both set counts and all queues; the stores need no clearing.
// A full result queue stalls the walk; the request queue fills its 2 entries.
// ----------------------------------------------------------------------------
module sorted_set_algebra_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic signed [31:0] element_value,
	input  logic [2:0]        operation,
	output logic              empty,
	input  logic              pop,
	output logic signed [31:0] result_value,
	output logic signed [31:0] pair_second,
	output logic              last_flag,
	output logic              empty_flag,
	output logic [1:0]        status
);
	import ssae_pkg::*;

	logic cmd_valid, cmd_take;
	cmd_t cmd;
	res_t res;

	ssae_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .element_value, .operation,
		.cmd_valid, .cmd_take, .cmd
	);

	ssae_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.res_empty(empty), .pop, .res
	);

	assign result_value = res.value;
	assign pair_second  = res.second;
	assign last_flag    = res.last;
	assign empty_flag   = res.empty;
	assign status       = res.status;

endmodule
